>>> src/json_utf8_stream_validator_top_macros.svh
// ----------------------------------------------------------------------------
// JSON UTF-8 stream validator: assertion macros
// Concurrent assertion wrappers on the block clock with reset masking.
// ----------------------------------------------------------------------------
`ifndef JSON_UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH
`define JSON_UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication
`define JUSV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JUSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/jusv_pkg.sv
// ----------------------------------------------------------------------------
// JSON UTF-8 stream validator: package
// Payload types, byte codes and code point limits.
// ----------------------------------------------------------------------------
package jusv_pkg;

    localparam int CODE_W = 21;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic still_valid;
        logic verdict_final;
    } t_out_item;

    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_NONASC = 8'h80;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam logic [1:0] TAIL_BITS = 2'b10;

    localparam logic [CODE_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI = 21'h00DFFF;

    function automatic logic [CODE_W-1:0] min_code(input logic [1:0] lead_class);
        logic [CODE_W-1:0] v;
        case (lead_class)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/jusv_stream_if.sv
// ----------------------------------------------------------------------------
// JSON UTF-8 stream validator: stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface jusv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/json_utf8_stream_validator_top.sv
// ----------------------------------------------------------------------------
// JSON UTF-8 stream validator: top level
// Checks a byte stream for strict UTF-8 and JSON control-byte rules and
// returns a running verdict for every byte.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                      | Transfer
// i_in    | in  | data_byte[7:0], frame_end    | valid && ready
// o_out   | out | still_valid, verdict_final   | valid && ready
//
// One byte per cycle sustained unless the output stalls.
// The running state (string, escape, tails, code point, error) updates once
// per byte in a single combinational step between input and result register.
// i_rst_n is synchronous, active low, and clears all state and valids.
// A stalled output holds both stages; the input stays ready while the input
// register is empty or the result register drains.
// ----------------------------------------------------------------------------
`include "json_utf8_stream_validator_top_macros.svh"

module json_utf8_stream_validator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jusv_stream_if.sink   i_in,
    jusv_stream_if.source o_out
);
    import jusv_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic              r_inside_string, n_inside_string;
    logic              r_escape_pending, n_escape_pending;
    logic [1:0]        r_tails_left, n_tails_left;
    logic [CODE_W-1:0] r_code_accum, n_code_accum;
    logic [1:0]        r_lead_class, n_lead_class;
    logic              r_error_seen, n_error_seen;

    t_out_item         n_out_item;
    logic              advance;
    logic              step;
    logic [7:0]        c;
    logic              last;
    logic [CODE_W-1:0] shifted;

    assign advance     = !r_out_valid || o_out.ready;
    assign step        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    assign c       = r_in_item.data_byte;
    assign last    = r_in_item.frame_end;
    assign shifted = {r_code_accum[CODE_W-7:0], c[5:0]};

    always_comb begin
        n_inside_string  = r_inside_string;
        n_escape_pending = r_escape_pending;
        n_tails_left     = r_tails_left;
        n_code_accum     = r_code_accum;
        n_lead_class     = r_lead_class;
        n_error_seen     = r_error_seen;

        if (!r_error_seen) begin
            if (r_tails_left != 2'd0) begin
                if (c[7:6] != TAIL_BITS) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_code_accum = shifted;
                    n_tails_left = r_tails_left - 2'd1;
                    if (r_tails_left == 2'd1) begin
                        if (shifted < min_code(r_lead_class) || shifted > CP_MAX ||
                            (shifted >= SURR_LO && shifted <= SURR_HI)) begin
                            n_error_seen = 1'b1;
                        end
                    end
                end
            end else if (c < CHR_SPACE) begin
                if (r_inside_string || (c != CHR_TAB && c != CHR_LF && c != CHR_CR)) begin
                    n_error_seen = 1'b1;
                end
            end else if (c < CHR_NONASC) begin
                if (r_inside_string) begin
                    if (r_escape_pending) begin
                        n_escape_pending = 1'b0;
                    end else if (c == CHR_BSLASH) begin
                        n_escape_pending = 1'b1;
                    end else if (c == CHR_QUOTE) begin
                        n_inside_string = 1'b0;
                    end
                end else if (c == CHR_QUOTE) begin
                    n_inside_string = 1'b1;
                end
            end else begin
                case (c) inside
                    [LEAD2_LO:LEAD2_HI]: begin
                        n_tails_left = 2'd1;
                        n_lead_class = 2'd1;
                        n_code_accum = {{(CODE_W-5){1'b0}}, c[4:0]};
                    end
                    [LEAD3_LO:LEAD3_HI]: begin
                        n_tails_left = 2'd2;
                        n_lead_class = 2'd2;
                        n_code_accum = {{(CODE_W-4){1'b0}}, c[3:0]};
                    end
                    [LEAD4_LO:LEAD4_HI]: begin
                        n_tails_left = 2'd3;
                        n_lead_class = 2'd3;
                        n_code_accum = {{(CODE_W-3){1'b0}}, c[2:0]};
                    end
                    default: begin
                        n_error_seen = 1'b1;
                    end
                endcase
            end
        end

        if (last && n_tails_left != 2'd0) begin
            n_error_seen = 1'b1;
        end

        n_out_item.still_valid   = !n_error_seen;
        n_out_item.verdict_final = last;

        if (last) begin
            n_inside_string  = 1'b0;
            n_escape_pending = 1'b0;
            n_tails_left     = 2'd0;
            n_code_accum     = '0;
            n_lead_class     = 2'd0;
            n_error_seen     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_inside_string  <= 1'b0;
            r_escape_pending <= 1'b0;
            r_tails_left     <= 2'd0;
            r_code_accum     <= '0;
            r_lead_class     <= 2'd0;
            r_error_seen     <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_inside_string  <= n_inside_string;
                r_escape_pending <= n_escape_pending;
                r_tails_left     <= n_tails_left;
                r_code_accum     <= n_code_accum;
                r_lead_class     <= n_lead_class;
                r_error_seen     <= n_error_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (step) begin
            r_out_item <= n_out_item;
        end
    end

    `JUSV_ASSERT_NEXT(a_clear_after_final, step && last,
        r_tails_left == 2'd0 && !r_error_seen && !r_inside_string,
        "state not cleared after final byte")
    `JUSV_ASSERT_NOW(a_verdict_tracks_error, r_out_valid && !r_out_item.verdict_final,
        r_out_item.still_valid == !r_error_seen,
        "running verdict disagrees with error flag")
    `JUSV_ASSERT_NOW(a_escape_in_string, r_escape_pending, r_inside_string,
        "escape pending outside a string")
    `JUSV_ASSERT_NOW(a_tails_within_class, r_tails_left != 2'd0,
        r_tails_left <= r_lead_class,
        "more tails expected than the lead byte allows")
    `JUSV_ASSERT_NOW(a_stall_only_on_backpressure, !i_in.ready,
        r_out_valid && !o_out.ready,
        "input stalled without output backpressure")

endmodule
